// ===== sv/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the lubrication pump guard.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   localparam int TICK_W    = 20;
   localparam int TIME_W    = 32;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int REQ_DW    = 24;
   localparam int RSP_DW    = 8;

   localparam logic [TIME_W-1:0] HOLD_TIME_RST    = 32'd1000000;
   localparam logic [TIME_W-1:0] PRESS_TIMEOUT_RST = 32'd5000000;

   // register indexes
   typedef enum logic [2:0] {
      REG_HOLD_TIME     = 3'd0,
      REG_PRESS_TIMEOUT = 3'd1,
      REG_INV_ENABLE    = 3'd2,
      REG_INV_PRESSURE  = 3'd3,
      REG_INV_RESET     = 3'd4
   } reg_idx_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WAIT = 2'd1,
      MODE_HOLD = 2'd2
   } mode_type;

   typedef struct packed {
      logic [TIME_W-1:0] hold_time_us;
      logic [TIME_W-1:0] pressure_timeout_us;
      logic              invert_enable;
      logic              invert_pressure;
      logic              invert_reset;
   } cfg_type;

   typedef struct packed {
      logic              reset_raw;
      logic              pressure_raw;
      logic              enable_raw;
      logic [TICK_W-1:0] tick_us;
   } req_type;

   typedef struct packed {
      logic [1:0] mode_code;
      logic       pressure_timeout;
      logic       fault;
      logic       busy_res;
      logic       motor_on;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/lubrication_pump_guard.sv =====
// ----------------------------------------------------------------------------
// lubrication_pump_guard
// Lubrication pump supervisor: input register, one-pass mode logic, result
// register with stream handshakes and an APB-style configuration port.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and its result is
// registered in the result register once that register is free or taken.
// Throughput: 1 item per cycle; input and result registers stall together
// only when the result register is full and not taken.
// Reset: synchronous; clears the mode, counter, latches, valid flags and
// returns all configuration registers to their reset values.
`default_nettype none

module lubrication_pump_guard (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // tdata: tick_us[19:0], enable_raw[20], pressure_raw[21], reset_raw[22], 0
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [lpg_pkg::REQ_DW-1:0]   req_tdata,
   // tdata: motor_on[0], busy_res[1], fault[2], pressure_timeout[3],
   //        mode_code[5:4], 0
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [lpg_pkg::RSP_DW-1:0]   rsp_tdata,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [lpg_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [lpg_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [lpg_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import lpg_pkg::*;

   cfg_type  cfg;
   req_type  in_data_ff;
   logic     in_valid_ff, in_valid_in;
   rsp_type  rsp_core;
   rsp_type  out_data_ff;
   logic     out_valid_ff, out_valid_in;
   logic     advance, fire, req_fire;

   lpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpg_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .cfg   (cfg),
      .req   (in_data_ff),
      .rsp   (rsp_core)
   );

   // pipeline flow control
   assign advance     = !out_valid_ff || rsp_tready;
   assign fire        = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata[$bits(req_type)-1:0];
      end
      if (fire) begin
         out_data_ff <= rsp_core;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-$bits(rsp_type)){1'b0}}, out_data_ff};

   // a latched fault keeps the motor off and reports idle
   a_fault_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_data_ff.fault |->
         !out_data_ff.motor_on && out_data_ff.mode_code == MODE_IDLE)
      else $error("fault reported with motor on or non-idle mode");

   // the fault latch never stands without the timeout flag
   a_fault_tout: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_data_ff.fault |-> out_data_ff.pressure_timeout)
      else $error("fault without timeout flag");

   // an item in the input register moves to the result register when free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> rsp_tvalid)
      else $error("input stage advanced without producing a result");

endmodule

`default_nettype wire

// ===== sv/lpg_csr.sv =====
// ----------------------------------------------------------------------------
// lpg_csr
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [lpg_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [lpg_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [lpg_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                              csr_pready,
   output lpg_pkg::cfg_type                  cfg
);
   import lpg_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   reg_idx_type  idx;
   logic         wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_HOLD_TIME:     cfg_in.hold_time_us        = csr_pwdata;
            REG_PRESS_TIMEOUT: cfg_in.pressure_timeout_us = csr_pwdata;
            REG_INV_ENABLE:    cfg_in.invert_enable       = csr_pwdata[0];
            REG_INV_PRESSURE:  cfg_in.invert_pressure     = csr_pwdata[0];
            REG_INV_RESET:     cfg_in.invert_reset        = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time_us        <= HOLD_TIME_RST;
         cfg_ff.pressure_timeout_us <= PRESS_TIMEOUT_RST;
         cfg_ff.invert_enable       <= 1'b0;
         cfg_ff.invert_pressure     <= 1'b0;
         cfg_ff.invert_reset        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_HOLD_TIME:     csr_prdata = cfg_ff.hold_time_us;
         REG_PRESS_TIMEOUT: csr_prdata = cfg_ff.pressure_timeout_us;
         REG_INV_ENABLE:    csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.invert_enable};
         REG_INV_PRESSURE:  csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.invert_pressure};
         REG_INV_RESET:     csr_prdata = {{(CSR_DW-1){1'b0}}, cfg_ff.invert_reset};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/lpg_core.sv =====
// ----------------------------------------------------------------------------
// lpg_core
// Mode machine, fault latches and saturating elapsed counter; one tick per
// step, next state and result worked out in a single combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  lpg_pkg::cfg_type      cfg,
   input  lpg_pkg::req_type      req,
   output lpg_pkg::rsp_type      rsp
);
   import lpg_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic               fault_ff, fault_in;
   logic               tout_ff, tout_in;

   logic               en, press, rst;
   mode_type           mode_0;
   logic [TIME_W-1:0]  elapsed_0;
   logic [TIME_W:0]    sum;
   logic [TIME_W-1:0]  sat;
   logic               motor;

   // input polarity
   assign en    = req.enable_raw   ^ cfg.invert_enable;
   assign press = req.pressure_raw ^ cfg.invert_pressure;
   assign rst   = req.reset_raw    ^ cfg.invert_reset;

   // fault reset without enable drops back to idle
   assign mode_0    = (rst && !en) ? MODE_IDLE : mode_ff;
   assign elapsed_0 = (rst && !en) ? '0 : elapsed_ff;

   // saturating add of the tick
   assign sum = {1'b0, elapsed_0} + {{(TIME_W+1-TICK_W){1'b0}}, req.tick_us};
   assign sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

   // next state and result
   always_comb begin
      mode_in    = mode_0;
      elapsed_in = elapsed_0;
      fault_in   = rst ? 1'b0 : fault_ff;
      tout_in    = rst ? 1'b0 : tout_ff;
      motor      = 1'b0;
      if (!fault_in) begin
         unique case (mode_0)
            MODE_IDLE: begin
               if (en) begin
                  tout_in    = 1'b0;
                  mode_in    = MODE_WAIT;
                  elapsed_in = '0;
               end
            end
            MODE_WAIT: begin
               motor = 1'b1;
               if (press) begin
                  mode_in    = MODE_HOLD;
                  elapsed_in = '0;
               end else if (sat >= cfg.pressure_timeout_us) begin
                  fault_in   = 1'b1;
                  tout_in    = 1'b1;
                  motor      = 1'b0;
                  mode_in    = MODE_IDLE;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = sat;
               end
            end
            MODE_HOLD: begin
               motor = 1'b1;
               if (sat >= cfg.hold_time_us) begin
                  motor      = 1'b0;
                  mode_in    = MODE_IDLE;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = sat;
               end
            end
            default: begin
               mode_in    = MODE_IDLE;
               elapsed_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp.motor_on         = motor;
      rsp.busy_res         = motor;
      rsp.fault            = fault_in;
      rsp.pressure_timeout = tout_in;
      rsp.mode_code        = fault_in ? MODE_IDLE : mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         elapsed_ff <= '0;
         fault_ff   <= 1'b0;
         tout_ff    <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         fault_ff   <= fault_in;
         tout_ff    <= tout_in;
      end
   end

endmodule

`default_nettype wire
